[rtl/lom_pkg.sv]
// ----------------------------------------------------------------------------
// lom_pkg: shared types for the limit order matcher
// Entry, scan wave, request broadcast and update command types.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int unsigned BOOK_DEPTH_DEF = 32;
    // index field wide enough for the largest supported book
    localparam int unsigned IDXW = 10;

    localparam logic [1:0] FUNC_PLACE_BUY  = 2'd0;
    localparam logic [1:0] FUNC_PLACE_SELL = 2'd1;
    localparam logic [1:0] FUNC_CANCEL_BUY = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic BOOK_BUY  = 1'b0;
    localparam logic BOOK_SELL = 1'b1;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_FREE,
        SCAN_CANCEL
    } scan_mode_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_DEC,
        CMD_CLEAR,
        CMD_WRITE
    } cmd_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRADE_OUT,
        S_LAST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] owner;
        logic [23:0] rem;
        logic [23:0] price;
        logic [15:0] instr;
    } entry_t;

    typedef struct packed {
        logic            vld;
        logic            found;
        logic [IDXW-1:0] idx;
        logic [23:0]     price;
        logic [31:0]     id;
        logic [23:0]     rem;
        logic [15:0]     owner;
    } wave_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic        book;
        logic [15:0] instr;
        logic [23:0] limit;
        logic [15:0] trader;
        logic [31:0] ref_id;
    } req_t;

    typedef struct packed {
        cmd_op_t         op;
        logic            book;
        logic [IDXW-1:0] idx;
        logic [23:0]     amount;
        entry_t          ent;
    } cmd_t;

endpackage

[rtl/lom_if.sv]
// ----------------------------------------------------------------------------
// lom_if: handshake channels of the limit order matcher
// Request channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface lom_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] trader;
    logic [15:0] instrument;
    logic [23:0] limit_price;
    logic [23:0] quantity;
    logic [31:0] order_ref;

    modport source (output valid, func, trader, instrument, limit_price, quantity,
                    order_ref, input ready);
    modport sink (input valid, func, trader, instrument, limit_price, quantity,
                  order_ref, output ready);
endinterface

interface lom_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [23:0] trade_price;
    logic [23:0] trade_quantity;
    logic [15:0] buyer_id;
    logic [15:0] seller_id;
    logic [15:0] trade_instrument;
    logic [1:0]  status;
    logic [31:0] resting_id;
    logic        last;

    modport source (output valid, kind, trade_price, trade_quantity, buyer_id,
                    seller_id, trade_instrument, status, resting_id, last,
                    input ready);
    modport sink (input valid, kind, trade_price, trade_quantity, buyer_id,
                  seller_id, trade_instrument, status, resting_id, last,
                  output ready);
endinterface

[rtl/limit_order_matcher.sv]
// ----------------------------------------------------------------------------
// limit_order_matcher: price-time priority limit order book
// Buy and sell books held in a chain of slot cells searched by a scan wave.
// ----------------------------------------------------------------------------
// Each book search is a wave that passes through the BOOK_DEPTH cells in turn.
// Cancel: one search to the status result; zero quantity: status with no search.
// Place: one search per trade, plus a failed match search and a free slot
// search when a remainder is left; each trade and then the status are output.
// One request at a time; the next is taken after the status transfer.
// Reset empties both books and sets the next order id to one.
module limit_order_matcher #(
    parameter int unsigned BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lom_req_if.sink   req,
    lom_res_if.source res
);
    import lom_pkg::*;

    // scan chain: waves[0] is launched here, waves[BOOK_DEPTH] is the answer
    wave_t  waves [BOOK_DEPTH+1];

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    cmd_t        cmd_reg, cmd_next;
    logic        launch_reg, launch_next;
    logic        taker_buy_reg, taker_buy_next;
    logic [23:0] qty_reg, qty_next;
    logic [31:0] next_id_reg, next_id_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [23:0] price_reg, price_next;
    logic [23:0] tqty_reg, tqty_next;
    logic [15:0] buyer_reg, buyer_next;
    logic [15:0] seller_reg, seller_next;
    logic [15:0] tinstr_reg, tinstr_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] rid_reg, rid_next;

    wave_t       ans;
    logic [23:0] fill;

    always_comb
    begin
        waves[0]       = '0;
        waves[0].vld   = launch_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < BOOK_DEPTH; gi++)
        begin : g_cell
            lom_cell #(.IDX(gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .req      (req_reg),
                .cmd      (cmd_reg),
                .wave_in  (waves[gi]),
                .wave_out (waves[gi+1])
            );
        end
    endgenerate

    assign ans  = waves[BOOK_DEPTH];
    assign fill = (ans.rem < qty_reg) ? ans.rem : qty_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.kind             = kind_reg;
    assign res.trade_price      = price_reg;
    assign res.trade_quantity   = tqty_reg;
    assign res.buyer_id         = buyer_reg;
    assign res.seller_id        = seller_reg;
    assign res.trade_instrument = tinstr_reg;
    assign res.status           = status_reg;
    assign res.resting_id       = rid_reg;
    assign res.last             = (kind_reg == KIND_STATUS);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cmd_next       = cmd_reg;
        cmd_next.op    = CMD_NONE;
        launch_next    = 1'b0;
        taker_buy_next = taker_buy_reg;
        qty_next       = qty_reg;
        next_id_next   = next_id_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        price_next     = price_reg;
        tqty_next      = tqty_reg;
        buyer_next     = buyer_reg;
        seller_next    = seller_reg;
        tinstr_next    = tinstr_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;

        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next.trader = req.trader;
                    req_next.instr  = req.instrument;
                    req_next.limit  = req.limit_price;
                    req_next.ref_id = req.order_ref;
                    qty_next        = req.quantity;
                    taker_buy_next  = (req.func == FUNC_PLACE_BUY);
                    if (req.func == FUNC_PLACE_BUY || req.func == FUNC_PLACE_SELL)
                    begin
                        // a buyer searches the sell book and vice versa
                        req_next.mode = SCAN_MATCH;
                        req_next.book = (req.func == FUNC_PLACE_BUY) ? BOOK_SELL
                                                                     : BOOK_BUY;
                    end
                    else
                    begin
                        req_next.mode = SCAN_CANCEL;
                        req_next.book = (req.func == FUNC_CANCEL_BUY) ? BOOK_BUY
                                                                      : BOOK_SELL;
                    end
                    if ((req.func == FUNC_PLACE_BUY || req.func == FUNC_PLACE_SELL)
                        && req.quantity == 24'd0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STATUS;
                        price_next     = '0;
                        tqty_next      = '0;
                        buyer_next     = '0;
                        seller_next    = '0;
                        tinstr_next    = '0;
                        status_next    = ST_DONE;
                        rid_next       = '0;
                        state_next     = S_LAST_OUT;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (ans.vld)
                begin
                    kind_next   = KIND_STATUS;
                    price_next  = '0;
                    tqty_next   = '0;
                    buyer_next  = '0;
                    seller_next = '0;
                    tinstr_next = '0;
                    status_next = ST_DONE;
                    rid_next    = '0;
                    cmd_next.book = req_reg.book;
                    cmd_next.idx  = ans.idx;
                    case (req_reg.mode)
                        SCAN_MATCH:
                        begin
                            if (ans.found)
                            begin
                                kind_next       = KIND_TRADE;
                                price_next      = ans.price;
                                tqty_next       = fill;
                                buyer_next      = taker_buy_reg ? req_reg.trader
                                                                : ans.owner;
                                seller_next     = taker_buy_reg ? ans.owner
                                                                : req_reg.trader;
                                tinstr_next     = req_reg.instr;
                                out_valid_next  = 1'b1;
                                cmd_next.op     = CMD_DEC;
                                cmd_next.amount = fill;
                                qty_next        = qty_reg - fill;
                                state_next      = S_TRADE_OUT;
                            end
                            else
                            begin
                                // no counterparty left: look for a free slot
                                req_next.mode = SCAN_FREE;
                                req_next.book = taker_buy_reg ? BOOK_BUY : BOOK_SELL;
                                launch_next   = 1'b1;
                            end
                        end
                        SCAN_FREE:
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_LAST_OUT;
                            if (ans.found)
                            begin
                                cmd_next.op        = CMD_WRITE;
                                cmd_next.ent.id    = next_id_reg;
                                cmd_next.ent.owner = req_reg.trader;
                                cmd_next.ent.rem   = qty_reg;
                                cmd_next.ent.price = req_reg.limit;
                                cmd_next.ent.instr = req_reg.instr;
                                rid_next           = next_id_reg;
                                next_id_next = (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                               : next_id_reg + 32'd1;
                            end
                            else
                                status_next = ST_FULL;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_LAST_OUT;
                            if (ans.found)
                                cmd_next.op = CMD_CLEAR;
                            else
                                status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_TRADE_OUT:
            begin
                if (res.ready)
                begin
                    if (qty_reg == 24'd0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STATUS;
                        price_next     = '0;
                        tqty_next      = '0;
                        buyer_next     = '0;
                        seller_next    = '0;
                        tinstr_next    = '0;
                        status_next    = ST_DONE;
                        rid_next       = '0;
                        state_next     = S_LAST_OUT;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_LAST_OUT:
            begin
                if (res.ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            next_id_reg   <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            next_id_reg   <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        taker_buy_reg <= taker_buy_next;
        qty_reg       <= qty_next;
        kind_reg      <= kind_next;
        price_reg     <= price_next;
        tqty_reg      <= tqty_next;
        buyer_reg     <= buyer_next;
        seller_reg    <= seller_next;
        tinstr_reg    <= tinstr_next;
        status_reg    <= status_next;
        rid_reg       <= rid_next;
    end

endmodule

[rtl/lom_cell.sv]
// ----------------------------------------------------------------------------
// lom_cell: one book slot
// Holds one buy and one sell entry; folds itself into the passing scan wave.
// ----------------------------------------------------------------------------
module lom_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lom_pkg::req_t  req,
    input  lom_pkg::cmd_t  cmd,
    input  lom_pkg::wave_t wave_in,
    output lom_pkg::wave_t wave_out
);
    import lom_pkg::*;

    logic   [1:0] valid_reg;
    logic   [1:0] valid_next;
    entry_t       ent_reg [2];
    wave_t        wave_reg;
    wave_t        wave_next;
    entry_t       e;
    logic         v;
    logic         take;
    logic         price_ok;
    logic         better;
    logic         hit;
    logic [23:0]  rem_left;

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    assign e = ent_reg[req.book];
    assign v = valid_reg[req.book];

    always_comb
    begin
        // a sell book entry matches a buyer at or below the limit
        price_ok = (req.book == BOOK_SELL) ? (e.price <= req.limit)
                                           : (e.price >= req.limit);
        better = (req.book == BOOK_SELL) ? (e.price < wave_in.price)
                                         : (e.price > wave_in.price);
        better = better || (e.price == wave_in.price && e.id < wave_in.id);
        case (req.mode)
            SCAN_MATCH:  take = v && e.instr == req.instr && price_ok
                                && (!wave_in.found || better);
            SCAN_FREE:   take = !v && !wave_in.found;
            SCAN_CANCEL: take = v && e.id == req.ref_id && e.owner == req.trader
                                && !wave_in.found;
            default:     take = 1'b0;
        endcase
        wave_next = wave_in;
        if (take)
        begin
            wave_next.found = 1'b1;
            wave_next.idx   = MY_IDX;
            wave_next.price = e.price;
            wave_next.id    = e.id;
            wave_next.rem   = e.rem;
            wave_next.owner = e.owner;
        end
    end

    assign hit      = (cmd.op != CMD_NONE) && cmd.idx == MY_IDX;
    assign rem_left = ent_reg[cmd.book].rem - cmd.amount;

    always_comb
    begin
        valid_next = valid_reg;
        if (hit)
        begin
            case (cmd.op)
                CMD_DEC:   valid_next[cmd.book] = (rem_left != 24'd0);
                CMD_CLEAR: valid_next[cmd.book] = 1'b0;
                CMD_WRITE: valid_next[cmd.book] = 1'b1;
                default:   valid_next[cmd.book] = valid_reg[cmd.book];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.op == CMD_DEC)
            ent_reg[cmd.book].rem <= rem_left;
        if (hit && cmd.op == CMD_WRITE)
            ent_reg[cmd.book] <= cmd.ent;
    end

    assign wave_out = wave_reg;

endmodule
